@@ rtl/mts_pkg.sv @@
// Package for the melody table sequencer: command and response word types,
// op codes, field widths and the note divider table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int MAX_NOTES_DEF = 256;
    localparam int FREQ_W        = 13;
    localparam int DUR_W         = 15;
    localparam int ELAPSED_W     = 15;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_BEGIN = 3'd1;
    localparam logic [2:0] OP_PAIR  = 3'd2;
    localparam logic [2:0] OP_END   = 3'd3;
    localparam logic [2:0] OP_MODE  = 3'd4;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [DUR_W-1:0]     DUR_MIN     = 15'd60;
    localparam logic [FREQ_W-1:0]    FREQ_DEFAULT = 13'd1000;
    localparam logic signed [15:0]   FREQ_LOW    = 16'sd31;
    localparam logic signed [15:0]   FREQ_HIGH   = 16'sd5000;
    localparam logic signed [15:0]   DIV_LIMIT   = 16'sd20;
    // floor(y / 10) = (y * DIV10_MUL) >> DIV10_SHIFT for any 16-bit y
    localparam logic [15:0]          DIV10_MUL   = 16'd52429;
    localparam int                   DIV10_SHIFT = 19;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] note_freq;
        logic signed [15:0] note_duration;
        logic               play_on;
    } cmd_t;

    typedef struct packed {
        logic [12:0] tone_freq;
        logic        tone_active;
        logic        is_playing;
        logic [7:0]  note_position;
        logic [8:0]  loaded_count;
        logic        pair_accepted;
    } rsp_t;

    // 1000 / d for note dividers 1..19
    function automatic logic [9:0] div1000(input logic [4:0] d);
        logic [9:0] r;
        case (d)
            5'd1:    r = 10'd1000;
            5'd2:    r = 10'd500;
            5'd3:    r = 10'd333;
            5'd4:    r = 10'd250;
            5'd5:    r = 10'd200;
            5'd6:    r = 10'd166;
            5'd7:    r = 10'd142;
            5'd8:    r = 10'd125;
            5'd9:    r = 10'd111;
            5'd10:   r = 10'd100;
            5'd11:   r = 10'd90;
            5'd12:   r = 10'd83;
            5'd13:   r = 10'd76;
            5'd14:   r = 10'd71;
            5'd15:   r = 10'd66;
            5'd16:   r = 10'd62;
            5'd17:   r = 10'd58;
            5'd18:   r = 10'd55;
            5'd19:   r = 10'd52;
            default: r = 10'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/melody_table_sequencer.sv @@
// Melody table sequencer top level: note tables, playback control, response register.
// Depends on mts_pkg.
//
// Usage: one command word per handshake on cmd (valid/stall); each command
// gives exactly one response word on rsp (valid/stall) with the status after
// the command. Commands: tick one millisecond, begin upload, append pair,
// end upload, set play mode.
// Sequence: an accepted command passes through the execute, settle and
// output states before its response is loaded; a tick of a running song
// also passes the tick state. The next command is accepted only back in
// idle, so commands do not overlap. This is set by the single read port of
// the note tables: each command reads the current note after its state
// update, and a tick adds a registered multiply for the 9/10 audible length.
// If the receiver stalls, the response waits in its register; one further
// command is worked on and then held until the register is free.
// Reset: empty table, upload closed, play mode off, silent. The table
// contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module melody_table_sequencer #(
    parameter int MAX_NOTES = mts_pkg::MAX_NOTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire mts_pkg::cmd_t cmd,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output mts_pkg::rsp_t      rsp
);

    localparam int IW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CW = $clog2(MAX_NOTES + 1);
    localparam int FW = mts_pkg::FREQ_W;
    localparam int DW = mts_pkg::DUR_W;
    localparam int EW = mts_pkg::ELAPSED_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_SETTLE,
        S_OUT
    } state_t;

    state_t        state_reg, state_next;
    mts_pkg::cmd_t item_reg, item_next;
    logic [CW-1:0] count_reg, count_next;
    logic          upload_reg, upload_next;
    logic          mode_reg, mode_next;
    logic          running_reg, running_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [EW-1:0] elapsed_reg, elapsed_next;
    logic          sounding_reg, sounding_next;
    logic          pend_reg, pend_next;
    logic          acc_reg, acc_next;
    logic [12:0]   q_reg, q_next;
    mts_pkg::rsp_t rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic [FW-1:0] freq_mem [MAX_NOTES];
    logic [DW-1:0] dur_mem  [MAX_NOTES];
    logic [FW-1:0] freq_rd_reg;
    logic [DW-1:0] dur_rd_reg;

    logic          mem_we;
    logic [FW-1:0] wr_freq;
    logic [DW-1:0] wr_dur;

    logic [15:0]   q_arg;
    logic [31:0]   q_prod;
    logic [EW-1:0] elapsed_inc;
    logic [DW-1:0] audible;
    logic [CW-1:0] idx_inc;
    logic          sound_final;
    logic          start_ok;

    always_comb
    begin
        q_arg       = 16'(dur_rd_reg) + 16'd9;
        q_prod      = 32'(q_arg) * 32'(mts_pkg::DIV10_MUL);
        elapsed_inc = (elapsed_reg < mts_pkg::ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
        audible     = dur_rd_reg - DW'(q_reg);
        idx_inc     = CW'(idx_reg) + 1'b1;
        sound_final = pend_reg ? (freq_rd_reg != '0) : sounding_reg;
        start_ok    = count_reg != '0;

        if (item_reg.note_duration < mts_pkg::DIV_LIMIT)
            wr_dur = DW'(mts_pkg::div1000(item_reg.note_duration[4:0]));
        else
            wr_dur = item_reg.note_duration[DW-1:0];
        if (wr_dur < mts_pkg::DUR_MIN)
            wr_dur = mts_pkg::DUR_MIN;

        if (item_reg.note_freq < 0)
            wr_freq = '0;
        else if (item_reg.note_freq != 0 && (item_reg.note_freq < mts_pkg::FREQ_LOW
                 || item_reg.note_freq > mts_pkg::FREQ_HIGH))
            wr_freq = mts_pkg::FREQ_DEFAULT;
        else
            wr_freq = item_reg.note_freq[FW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        upload_next    = upload_reg;
        mode_next      = mode_reg;
        running_next   = running_reg;
        idx_next       = idx_reg;
        elapsed_next   = elapsed_reg;
        sounding_next  = sounding_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        q_next         = q_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next  = cmd;
                    pend_next  = 1'b0;
                    acc_next   = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_SETTLE;
                unique case (item_reg.op)
                    mts_pkg::OP_TICK:
                    begin
                        if (running_reg && !start_ok)
                        begin
                            running_next  = 1'b0;
                            sounding_next = 1'b0;
                        end
                        else if (running_reg)
                        begin
                            q_next     = q_prod[mts_pkg::DIV10_SHIFT +: 13];
                            state_next = S_TICK;
                        end
                    end
                    mts_pkg::OP_BEGIN:
                    begin
                        count_next  = '0;
                        upload_next = 1'b1;
                    end
                    mts_pkg::OP_PAIR:
                    begin
                        if (upload_reg && count_reg < CW'(MAX_NOTES)
                            && item_reg.note_duration > 0)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            acc_next   = 1'b1;
                        end
                    end
                    mts_pkg::OP_END:
                    begin
                        if (upload_reg)
                        begin
                            idx_next = '0;
                            if (start_ok && mode_reg)
                            begin
                                running_next = 1'b1;
                                elapsed_next = '0;
                                pend_next    = 1'b1;
                            end
                            else
                            begin
                                running_next  = 1'b0;
                                sounding_next = 1'b0;
                            end
                        end
                        upload_next = 1'b0;
                    end
                    mts_pkg::OP_MODE:
                    begin
                        mode_next = item_reg.play_on;
                        if (!item_reg.play_on)
                        begin
                            running_next  = 1'b0;
                            idx_next      = '0;
                            sounding_next = 1'b0;
                        end
                        else if (start_ok)
                        begin
                            running_next = 1'b1;
                            idx_next     = '0;
                            elapsed_next = '0;
                            pend_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_TICK:
            begin
                state_next   = S_SETTLE;
                elapsed_next = elapsed_inc;
                if (sounding_reg && elapsed_inc >= audible)
                    sounding_next = 1'b0;
                if (elapsed_inc >= dur_rd_reg)
                begin
                    if (idx_inc >= count_reg)
                    begin
                        idx_next = '0;
                        if (mode_reg)
                        begin
                            elapsed_next = '0;
                            pend_next    = 1'b1;
                        end
                        else
                        begin
                            running_next  = 1'b0;
                            sounding_next = 1'b0;
                        end
                    end
                    else
                    begin
                        idx_next     = idx_inc[IW-1:0];
                        elapsed_next = '0;
                        pend_next    = 1'b1;
                    end
                end
            end
            S_SETTLE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    sounding_next          = sound_final;
                    pend_next              = 1'b0;
                    rsp_next.tone_freq     = (running_reg && sound_final) ? freq_rd_reg : '0;
                    rsp_next.tone_active   = running_reg && sound_final;
                    rsp_next.is_playing    = running_reg;
                    rsp_next.note_position = 8'(idx_reg);
                    rsp_next.loaded_count  = 9'(count_reg);
                    rsp_next.pair_accepted = acc_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            upload_reg    <= 1'b0;
            mode_reg      <= 1'b0;
            running_reg   <= 1'b0;
            idx_reg       <= '0;
            elapsed_reg   <= '0;
            sounding_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            acc_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            upload_reg    <= upload_next;
            mode_reg      <= mode_next;
            running_reg   <= running_next;
            idx_reg       <= idx_next;
            elapsed_reg   <= elapsed_next;
            sounding_reg  <= sounding_next;
            pend_reg      <= pend_next;
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        q_reg    <= q_next;
        rsp_reg  <= rsp_next;
    end

    // note tables: written at the fill count, read at the current note
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            freq_mem[count_reg[IW-1:0]] <= wr_freq;
            dur_mem[count_reg[IW-1:0]]  <= wr_dur;
        end
        freq_rd_reg <= freq_mem[idx_reg];
        dur_rd_reg  <= dur_mem[idx_reg];
    end

    assign cmd_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for melody_table_sequencer: directed and random command words, a
// status predictor kept in step with the block, and a field-by-field response check.
// Depends on mts_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int NOTES = mts_pkg::MAX_NOTES_DEF;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int AUDIBLE_NUM   = 9;
    localparam int AUDIBLE_DEN   = 10;
    localparam int MS_PER_SEC    = 1000;
    localparam int DUR_TOP       = 32767;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    mts_pkg::cmd_t cmd;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    mts_pkg::rsp_t rsp;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int pairs_stored = 0;
    int song_ends = 0;

    // player state as the block should hold it
    logic [mts_pkg::FREQ_W-1:0] freq_mem [NOTES];
    logic [mts_pkg::DUR_W-1:0]  dur_mem  [NOTES];
    int   notes_loaded = 0;
    bit   loading = 1'b0;
    bit   loop_mode = 1'b0;
    bit   playing = 1'b0;
    int   pos = 0;
    int   ms_count = 0;
    bit   tone_on = 1'b0;
    mts_pkg::rsp_t pending_status [$];

    melody_table_sequencer #(
        .MAX_NOTES(NOTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic void start_song();
        playing = 1'b1;
        pos = 0;
        ms_count = 0;
        tone_on = (freq_mem[0] != '0);
    endfunction

    function automatic void stop_song();
        playing = 1'b0;
        pos = 0;
        tone_on = 1'b0;
    endfunction

    function automatic void next_status(input mts_pkg::cmd_t c);
        mts_pkg::rsp_t st;
        int   f;
        int   d;
        int   span;
        bit   took;
        took = 1'b0;
        case (c.op)
            mts_pkg::OP_TICK:
            begin
                if (playing && notes_loaded == 0)
                begin
                    playing = 1'b0;
                    tone_on = 1'b0;
                end
                else if (playing)
                begin
                    if (ms_count < int'(mts_pkg::ELAPSED_MAX))
                        ms_count++;
                    span = dur_mem[pos];
                    if (tone_on && ms_count >= span * AUDIBLE_NUM / AUDIBLE_DEN)
                        tone_on = 1'b0;
                    if (ms_count >= span)
                    begin
                        pos++;
                        if (pos >= notes_loaded)
                        begin
                            song_ends++;
                            if (loop_mode)
                                start_song();
                            else
                                stop_song();
                        end
                        else
                        begin
                            ms_count = 0;
                            tone_on = (freq_mem[pos] != '0);
                        end
                    end
                end
            end
            mts_pkg::OP_BEGIN:
            begin
                notes_loaded = 0;
                loading = 1'b1;
            end
            mts_pkg::OP_PAIR:
            begin
                f = $signed(c.note_freq);
                d = $signed(c.note_duration);
                if (loading && notes_loaded < NOTES && d > 0)
                begin
                    if (d < int'(mts_pkg::DIV_LIMIT))
                        d = MS_PER_SEC / d;
                    if (d < int'(mts_pkg::DUR_MIN))
                        d = int'(mts_pkg::DUR_MIN);
                    if (f < 0)
                        f = 0;
                    if (f > 0 && (f < int'(mts_pkg::FREQ_LOW) || f > int'(mts_pkg::FREQ_HIGH)))
                        f = int'(mts_pkg::FREQ_DEFAULT);
                    freq_mem[notes_loaded] = f[mts_pkg::FREQ_W-1:0];
                    dur_mem[notes_loaded] = d[mts_pkg::DUR_W-1:0];
                    notes_loaded++;
                    pairs_stored++;
                    took = 1'b1;
                end
            end
            mts_pkg::OP_END:
            begin
                if (loading)
                begin
                    stop_song();
                    if (notes_loaded > 0 && loop_mode)
                        start_song();
                end
                loading = 1'b0;
            end
            mts_pkg::OP_MODE:
            begin
                loop_mode = c.play_on;
                if (!loop_mode)
                    stop_song();
                else if (notes_loaded > 0)
                    start_song();
            end
            default: ;
        endcase
        st.tone_freq = (playing && tone_on) ? freq_mem[pos] : '0;
        st.tone_active = playing && tone_on;
        st.is_playing = playing;
        st.note_position = 8'(pos);
        st.loaded_count = 9'(notes_loaded);
        st.pair_accepted = took;
        pending_status.push_back(st);
    endfunction

    // starts and ends at a falling edge; valid stays high for a following word
    task automatic send_word(input logic [2:0] op, input logic [15:0] freq,
                             input logic [15:0] dur, input logic play);
        mts_pkg::cmd_t w;
        w.op = op;
        w.note_freq = freq;
        w.note_duration = dur;
        w.play_on = play;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        next_status(w);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_op(input logic [2:0] op);
        send_word(op, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
    endtask

    task automatic send_mode(input logic on);
        send_word(mts_pkg::OP_MODE, 16'($urandom), 16'($urandom), on);
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_op(mts_pkg::OP_TICK);
    endtask

    task automatic send_random_pair();
        logic [15:0] f;
        logic [15:0] d;
        case ($urandom_range(9))
            0:       f = '0;
            1:       f = 16'h8000 | 16'($urandom);
            2:       f = 16'($urandom_range(1, int'(mts_pkg::FREQ_LOW) - 1));
            3:       f = 16'($urandom_range(int'(mts_pkg::FREQ_HIGH) + 1, DUR_TOP));
            default: f = 16'($urandom_range(int'(mts_pkg::FREQ_LOW),
                                            int'(mts_pkg::FREQ_HIGH)));
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4: d = 16'($urandom_range(int'(mts_pkg::DUR_MIN),
                                                  int'(mts_pkg::DUR_MIN) + 30));
            5, 6:          d = 16'($urandom_range(1, int'(mts_pkg::DIV_LIMIT) - 1));
            7:             d = 16'($urandom_range(int'(mts_pkg::DIV_LIMIT),
                                                  int'(mts_pkg::DUR_MIN) - 1));
            default:       d = 16'($urandom);
        endcase
        send_word(mts_pkg::OP_PAIR, f, d, 1'($urandom_range(1)));
    endtask

    always @(posedge clk)
    begin
        mts_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            words_checked++;
            if (pending_status.size() == 0)
            begin
                report_mismatch("status word with none expected", rsp, 0);
            end
            else
            begin
                want = pending_status.pop_front();
                if (rsp.tone_freq !== want.tone_freq)
                    report_mismatch("tone_freq", rsp.tone_freq, want.tone_freq);
                if (rsp.tone_active !== want.tone_active)
                    report_mismatch("tone_active", rsp.tone_active, want.tone_active);
                if (rsp.is_playing !== want.is_playing)
                    report_mismatch("is_playing", rsp.is_playing, want.is_playing);
                if (rsp.note_position !== want.note_position)
                    report_mismatch("note_position", rsp.note_position, want.note_position);
                if (rsp.loaded_count !== want.loaded_count)
                    report_mismatch("loaded_count", rsp.loaded_count, want.loaded_count);
                if (rsp.pair_accepted !== want.pair_accepted)
                    report_mismatch("pair_accepted", rsp.pair_accepted, want.pair_accepted);
            end
        end
    end

    // commands that find no upload and no song
    task automatic test_idle_commands();
        send_op(mts_pkg::OP_TICK);
        send_op(mts_pkg::OP_END);
        send_word(mts_pkg::OP_PAIR, 16'd1000, 16'd100, 1'b0);
        for (int o = OP_SPARE_FIRST; o <= OP_SPARE_LAST; o++)
            send_word(3'(o), (o == OP_SPARE_LAST) ? '1 : '0, '1, 1'(o));
        send_word(mts_pkg::OP_MODE, '0, '0, 1'b1);
        send_word(mts_pkg::OP_MODE, '1, '1, 1'b0);
    endtask

    task automatic test_pair_normalization();
        send_op(mts_pkg::OP_BEGIN);
        send_word(mts_pkg::OP_PAIR, 16'sd32767, 16'sd32767, 1'b1);
        send_word(mts_pkg::OP_PAIR, -16'sd32768, -16'sd32768, 1'b0);
        send_word(mts_pkg::OP_PAIR, -16'sd1, 16'sd1, 1'b0);
        send_word(mts_pkg::OP_PAIR, 16'sd30, 16'sd19, 1'b1);
        send_word(mts_pkg::OP_PAIR, mts_pkg::FREQ_LOW, mts_pkg::DIV_LIMIT, 1'b0);
        send_word(mts_pkg::OP_PAIR, mts_pkg::FREQ_HIGH, 16'sd59, 1'b1);
        send_word(mts_pkg::OP_PAIR, 16'sd5001, 16'sd60, 1'b0);
        send_word(mts_pkg::OP_PAIR, 16'sd0, 16'sd0, 1'b1);
        send_word(mts_pkg::OP_PAIR, 16'sd1, -16'sd1, 1'b0);
        send_op(mts_pkg::OP_END);
    endtask

    // a short song with a rest, played through once and wrapped
    task automatic test_playback();
        send_op(mts_pkg::OP_BEGIN);
        send_word(mts_pkg::OP_PAIR, 16'sd440, 16'(mts_pkg::DUR_MIN), 1'b0);
        send_word(mts_pkg::OP_PAIR, 16'sd0, 16'sd16, 1'b1);
        send_op(mts_pkg::OP_END);
        send_mode(1'b1);
        send_ticks(130);
        send_mode(1'b0);
        send_op(mts_pkg::OP_TICK);
    endtask

    task automatic test_begin_during_play();
        send_mode(1'b1);
        send_ticks(10);
        send_op(mts_pkg::OP_BEGIN);
        send_op(mts_pkg::OP_TICK);
        send_random_pair();
        send_op(mts_pkg::OP_END);
        send_ticks(20);
        send_op(mts_pkg::OP_BEGIN);
        send_random_pair();
        send_ticks(5);
        send_op(mts_pkg::OP_END);
        send_ticks(10);
        send_mode(1'b0);
    endtask

    task automatic test_table_full();
        send_mode(1'b0);
        send_op(mts_pkg::OP_BEGIN);
        repeat (NOTES + 2)
            send_word(mts_pkg::OP_PAIR, 16'($urandom), 16'($urandom_range(1, DUR_TOP)),
                      1'($urandom_range(1)));
        send_op(mts_pkg::OP_END);
        send_mode(1'b1);
        send_ticks(3);
        send_mode(1'b0);
    endtask

    task automatic test_random_songs(input int target);
        int first;
        int ticks;
        first = words_sent;
        while (words_sent - first < target)
        begin
            if ($urandom_range(99) < 85)
                send_op(mts_pkg::OP_BEGIN);
            repeat ($urandom_range(1, 4))
                send_random_pair();
            if ($urandom_range(99) < 90)
                send_op(mts_pkg::OP_END);
            send_mode($urandom_range(99) < 75);
            ticks = $urandom_range(1) ? $urandom_range(15) : $urandom_range(60, 150);
            repeat (ticks)
            begin
                if ($urandom_range(99) < 5)
                    send_word(3'($urandom_range(OP_SPARE_LAST)), 16'($urandom),
                              16'($urandom), 1'($urandom_range(1)));
                else
                    send_op(mts_pkg::OP_TICK);
            end
        end
    endtask

    // response side holds off while commands keep coming
    task automatic test_backpressure();
        hold_left = HOLD_CYCLES;
        send_mode(1'b1);
        send_ticks(15);
    endtask

    initial
    begin
        int guard;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 82;
        test_idle_commands();
        test_pair_normalization();
        test_playback();
        test_begin_during_play();

        send_idle_pct = 82;
        recv_idle_pct = 6;
        test_random_songs(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_table_full();
        test_backpressure();

        cmd_valid <= 1'b0;
        guard = 0;
        while (pending_status.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (pending_status.size() != 0)
            report_mismatch("status words never returned", pending_status.size(), 0);

        $display("Run covered %0d command words and %0d status words,", words_sent,
                 words_checked);
        $display("with %0d pairs stored, %0d song ends and %0d mismatches.", pairs_stored,
                 song_ends, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ melody_table_sequencer.f @@
rtl/mts_pkg.sv
rtl/melody_table_sequencer.sv
sim/testbench.sv
